FILE: sv/rabt_pkg.sv
// package: types, constants and arithmetic helpers for the row bound tightener
`timescale 1ns / 1ps
package rabt_pkg;

  localparam int MaxEntries = 64;
  localparam int IdxW = $clog2(MaxEntries);
  localparam int CntW = $clog2(MaxEntries + 1);

  localparam logic [0:0] CFG_TOLERANCE = 1'b0;
  localparam logic [0:0] CFG_INF_THR = 1'b1;

  localparam logic signed [63:0] SMAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [63:0] coefficient;
    logic signed [63:0] column_lower;
    logic signed [63:0] column_upper;
    logic column_active;
    logic signed [63:0] rbnd_lo;
    logic signed [63:0] rbnd_hi;
    logic last_entry;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] new_lower;
    logic signed [63:0] new_upper;
    logic lower_tightened;
    logic upper_tightened;
    logic infeasible;
    logic last_result;
  } out_word_t;

  // divider request and response
  typedef struct packed {
    logic start;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [63:0] quo;
  } div_rsp_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
    logic signed [64:0] s;
    begin
      s = {x[63], x} + {y[63], y};
      if (s[64] != s[63]) sat_add = s[64] ? SMIN : SMAX;
      else sat_add = s[63:0];
    end
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
    logic signed [64:0] s;
    begin
      s = {x[63], x} - {y[63], y};
      if (s[64] != s[63]) sat_sub = s[64] ? SMIN : SMAX;
      else sat_sub = s[63:0];
    end
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    mag = v[63] ? (64'd0 - 64'(v)) : 64'(v);
  endfunction

  function automatic logic signed [63:0] from_sm(input logic neg, input logic [63:0] m);
    begin
      if (!neg) from_sm = m[63] ? SMAX : $signed(m);
      else if (m[63]) from_sm = SMIN;
      else from_sm = $signed(64'd0 - m);
    end
  endfunction

endpackage

FILE: sv/rabt_stream_if.sv
// valid/ready stream interface carrying one word
`timescale 1ns / 1ps
interface rabt_stream_if #(type word_t = logic);
  logic valid;
  logic ready;
  word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: sv/rabt_mul.sv
// sequential q32.32 multiplier: one 32x32 partial product per cycle, saturating
`timescale 1ns / 1ps
module rabt_mul import rabt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic done,
  output logic signed [63:0] prod
);
  logic [63:0] ua_r, ub_r;
  logic neg_r;
  logic [2:0] step_r;
  logic busy_r;
  logic [127:0] acc_r;
  logic [63:0] pp;
  logic [127:0] sh;
  logic done_r;

  always_comb begin
    pp = '0;
    sh = '0;
    case (step_r[1:0])
      2'd0: begin pp = 64'(ua_r[31:0]) * 64'(ub_r[31:0]); sh = {64'd0, pp}; end
      2'd1: begin pp = 64'(ua_r[31:0]) * 64'(ub_r[63:32]); sh = {32'd0, pp, 32'd0}; end
      2'd2: begin pp = 64'(ua_r[63:32]) * 64'(ub_r[31:0]); sh = {32'd0, pp, 32'd0}; end
      default: begin pp = 64'(ua_r[63:32]) * 64'(ub_r[63:32]); sh = {pp, 64'd0}; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ua_r <= mag(a);
        ub_r <= mag(b);
        neg_r <= a[63] != b[63];
        acc_r <= '0;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_r + sh;
        step_r <= step_r + 3'd1;
        if (step_r == 3'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  always_comb begin
    if (acc_r[127:96] != '0) prod = neg_r ? SMIN : SMAX;
    else prod = from_sm(neg_r, acc_r[95:32]);
  end
endmodule

FILE: sv/rabt_div.sv
// restoring divider: (n * 2^32) / d, one quotient bit per cycle, saturating
`timescale 1ns / 1ps
module rabt_div import rabt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [63:0] r_r, lo_r, den_r, q_r;
  logic neg_r, sat_r, busy_r, done_r;
  logic [5:0] bit_r;
  logic [64:0] rs;
  logic [63:0] nm, dm;

  assign nm = mag(req.num);
  assign dm = mag(req.den);
  assign rs = {r_r, lo_r[63]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        neg_r <= req.num[63] != req.den[63];
        den_r <= dm;
        r_r <= {32'd0, nm[63:32]};
        lo_r <= {nm[31:0], 32'd0};
        q_r <= '0;
        bit_r <= '0;
        if (dm == '0 || {32'd0, nm[63:32]} >= dm) begin
          sat_r <= 1'b1;
          done_r <= 1'b1;
        end else begin
          sat_r <= 1'b0;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        lo_r <= {lo_r[62:0], 1'b0};
        if (rs >= {1'b0, den_r}) begin
          r_r <= 64'(rs - {1'b0, den_r});
          q_r <= {q_r[62:0], 1'b1};
        end else begin
          r_r <= rs[63:0];
          q_r <= {q_r[62:0], 1'b0};
        end
        bit_r <= bit_r + 6'd1;
        if (bit_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo = sat_r ? (neg_r ? SMIN : SMAX) : from_sm(neg_r, q_r);
endmodule

FILE: sv/row_activity_bound_tightener.sv
// top level: row entry loading, activity sums and per-entry bound tightening
`timescale 1ns / 1ps
// Loads one row entry per accepted word; an active entry with a nonzero
// coefficient runs two products through the shared 4-step multiplier and holds
// the input not ready until both are accumulated, any other entry only through
// S_FIN. On the word marked last_entry the block emits one result per stored
// entry in load order. A tightened entry takes one multiply and one 64-step
// division for each side that applies, two of each when both sides apply, and a
// saturating division ends without iterating. The input is not ready while a
// row is processed or a result waits. Entries beyond 64 are dropped; their last
// mark still starts emission. An entry marked infeasible ends the row early.
module row_activity_bound_tightener import rabt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rabt_stream_if.sink in_ch,
  rabt_stream_if.source out_ch,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [62:0] cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0, S_ACC1 = 4'd1, S_ACC1W = 4'd2, S_ACC2 = 4'd3,
                         S_ACC2W = 4'd4, S_RD = 4'd5, S_RDW = 4'd6, S_M1W = 4'd7,
                         S_D1W = 4'd8, S_M2W = 4'd9, S_D2W = 4'd10, S_FIN = 4'd11,
                         S_OUT = 4'd12, S_M1 = 4'd13, S_D1 = 4'd14, S_D2 = 4'd15;

  logic [3:0] st_r;
  logic [32:0] tol_r;
  logic [62:0] thr_r;
  logic signed [63:0] min_act_r, max_act_r, rl_r, ru_r;
  logic [CntW-1:0] min_inf_r, max_inf_r, act_cnt_r, ent_cnt_r, k_r;
  logic [63:0] coef_mem [MaxEntries];
  logic [63:0] lo_mem [MaxEntries];
  logic [63:0] hi_mem [MaxEntries];
  logic act_mem [MaxEntries];
  logic signed [63:0] a_r, olo_r, ohi_r, lb_r, ub_r;
  logic act_k_r, lt_r, ut_r, last_r;
  logic signed [63:0] ea_r, elo_r, ehi_r;
  logic eact_r;
  logic signed [63:0] num_r;
  logic mstart;
  logic signed [63:0] ma, mb, mp;
  logic mdone;
  div_req_t dreq;
  div_rsp_t drsp;
  out_word_t ow_r;
  logic ov_r;
  logic signed [63:0] thr_s, eps_s;

  assign thr_s = $signed({1'b0, thr_r});
  assign eps_s = $signed({31'd0, tol_r});

  rabt_mul u_mul (.clk, .rst_n, .start(mstart), .a(ma), .b(mb), .done(mdone), .prod(mp));
  rabt_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  logic lo_inf_e, hi_inf_e;
  assign lo_inf_e = elo_r <= -thr_s;
  assign hi_inf_e = ehi_r >= thr_s;

  logic min_inf_k, max_inf_k, use_min, use_max;
  logic signed [63:0] from_min, from_max;
  assign from_min = a_r[63] ? ohi_r : olo_r;
  assign from_max = a_r[63] ? olo_r : ohi_r;
  assign min_inf_k = a_r[63] ? (ohi_r >= thr_s) : (olo_r <= -thr_s);
  assign max_inf_k = a_r[63] ? (olo_r <= -thr_s) : (ohi_r >= thr_s);
  assign use_min = ru_r < thr_s && min_inf_r == CntW'(min_inf_k);
  assign use_max = rl_r > -thr_s && max_inf_r == CntW'(max_inf_k);

  logic tight_k;
  assign tight_k = act_cnt_r > CntW'(1) && act_k_r && a_r != '0;

  always_comb begin
    mstart = 1'b0;
    ma = ea_r;
    mb = elo_r;
    dreq = '0;
    case (st_r)
      S_ACC1: begin
        mstart = 1'b1;
        mb = ea_r[63] ? ehi_r : elo_r;
      end
      S_ACC2: begin
        mstart = 1'b1;
        mb = ea_r[63] ? elo_r : ehi_r;
      end
      S_M1: begin
        mstart = 1'b1;
        ma = a_r;
        mb = from_min;
      end
      S_D1, S_D2: begin
        dreq.start = 1'b1;
        dreq.num = num_r;
        dreq.den = a_r;
      end
      S_D1W: if ((drsp.done || !use_min) && use_max) begin
        mstart = 1'b1;
        ma = a_r;
        mb = from_max;
      end
      default: ;
    endcase
  end

  assign in_ch.ready = st_r == S_IDLE && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.data = ow_r;

  logic in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 33'd4;
      thr_r <= 63'h4000_0000_0000_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOLERANCE: tol_r <= cfg_data[32:0];
        CFG_INF_THR: thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry stores
  always_ff @(posedge clk) begin
    if (in_fire && ent_cnt_r < CntW'(MaxEntries)) begin
      coef_mem[ent_cnt_r[IdxW-1:0]] <= in_ch.data.coefficient;
      lo_mem[ent_cnt_r[IdxW-1:0]] <= in_ch.data.column_lower;
      hi_mem[ent_cnt_r[IdxW-1:0]] <= in_ch.data.column_upper;
      act_mem[ent_cnt_r[IdxW-1:0]] <= in_ch.data.column_active;
    end
    if (st_r == S_RD) begin
      a_r <= coef_mem[k_r[IdxW-1:0]];
      olo_r <= lo_mem[k_r[IdxW-1:0]];
      ohi_r <= hi_mem[k_r[IdxW-1:0]];
      act_k_r <= act_mem[k_r[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      min_act_r <= '0;
      max_act_r <= '0;
      min_inf_r <= '0;
      max_inf_r <= '0;
      act_cnt_r <= '0;
      ent_cnt_r <= '0;
      rl_r <= '0;
      ru_r <= '0;
      k_r <= '0;
      last_r <= 1'b0;
    end else begin
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_fire) begin
          last_r <= in_ch.data.last_entry;
          ea_r <= in_ch.data.coefficient;
          elo_r <= in_ch.data.column_lower;
          ehi_r <= in_ch.data.column_upper;
          eact_r <= in_ch.data.column_active;
          if (ent_cnt_r < CntW'(MaxEntries)) begin
            if (ent_cnt_r == '0) begin
              rl_r <= in_ch.data.rbnd_lo;
              ru_r <= in_ch.data.rbnd_hi;
            end
            ent_cnt_r <= ent_cnt_r + CntW'(1);
            if (in_ch.data.column_active) begin
              act_cnt_r <= act_cnt_r + CntW'(1);
              st_r <= (in_ch.data.coefficient != '0) ? S_ACC1 : S_FIN;
            end else st_r <= S_FIN;
          end else st_r <= S_FIN;
        end
        S_ACC1: begin
          // the multiplier always runs; infinite sides just count
          st_r <= S_ACC1W;
        end
        S_ACC1W: if (mdone) begin
          if (ea_r[63] ? hi_inf_e : lo_inf_e) min_inf_r <= min_inf_r + CntW'(1);
          else min_act_r <= sat_add(min_act_r, mp);
          st_r <= S_ACC2;
        end
        S_ACC2: st_r <= S_ACC2W;
        S_ACC2W: if (mdone) begin
          if (ea_r[63] ? lo_inf_e : hi_inf_e) max_inf_r <= max_inf_r + CntW'(1);
          else max_act_r <= sat_add(max_act_r, mp);
          st_r <= S_FIN;
        end
        S_FIN: begin
          k_r <= '0;
          st_r <= last_r ? S_RD : S_IDLE;
        end
        S_RD: begin
          if (k_r == ent_cnt_r) begin
            // row done, clear for the next
            min_act_r <= '0;
            max_act_r <= '0;
            min_inf_r <= '0;
            max_inf_r <= '0;
            act_cnt_r <= '0;
            ent_cnt_r <= '0;
            rl_r <= '0;
            ru_r <= '0;
            st_r <= S_IDLE;
          end else st_r <= S_RDW;
        end
        S_RDW: begin
          lb_r <= olo_r;
          ub_r <= ohi_r;
          lt_r <= 1'b0;
          ut_r <= 1'b0;
          if (!tight_k) st_r <= S_OUT;
          else if (use_min) st_r <= S_M1;
          else if (use_max) st_r <= S_D1W;
          else st_r <= S_OUT;
        end
        S_M1: st_r <= S_M1W;
        S_M1W: if (mdone) begin
          num_r <= sat_sub(ru_r, min_inf_k ? min_act_r : sat_sub(min_act_r, mp));
          st_r <= S_D1;
        end
        S_D1: st_r <= S_D1W;
        S_D1W: begin
          // entered directly when only the max side applies
          if (drsp.done || !use_min) begin
            if (drsp.done) begin
              if (!a_r[63]) begin
                if (drsp.quo < sat_sub(ub_r, eps_s)) begin ub_r <= drsp.quo; ut_r <= 1'b1; end
              end else begin
                if (drsp.quo > sat_add(lb_r, eps_s)) begin lb_r <= drsp.quo; lt_r <= 1'b1; end
              end
            end
            st_r <= use_max ? S_M2W : S_OUT;
          end
        end
        S_M2W: if (mdone) begin
          num_r <= sat_sub(rl_r, max_inf_k ? max_act_r : sat_sub(max_act_r, mp));
          st_r <= S_D2;
        end
        S_D2: st_r <= S_D2W;
        S_D2W: if (drsp.done) begin
          if (!a_r[63]) begin
            if (drsp.quo > sat_add(lb_r, eps_s)) begin lb_r <= drsp.quo; lt_r <= 1'b1; end
          end else begin
            if (drsp.quo < sat_sub(ub_r, eps_s)) begin ub_r <= drsp.quo; ut_r <= 1'b1; end
          end
          st_r <= S_OUT;
        end
        S_OUT: if (!ov_r) begin
          ov_r <= 1'b1;
          ow_r.new_lower <= lb_r;
          ow_r.new_upper <= ub_r;
          ow_r.lower_tightened <= lt_r;
          ow_r.upper_tightened <= ut_r;
          ow_r.infeasible <= tight_k && lb_r > sat_add(ub_r, eps_s);
          ow_r.last_result <= (tight_k && lb_r > sat_add(ub_r, eps_s))
                              || k_r + CntW'(1) == ent_cnt_r;
          k_r <= (tight_k && lb_r > sat_add(ub_r, eps_s)) ? ent_cnt_r : k_r + CntW'(1);
          st_r <= S_RD;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/rabt_checker.sv
// port-level checker for the row bound tightener, bound to the top level
`timescale 1ns / 1ps
module rabt_checker import rabt_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_word_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while stalled");
  a_infeas_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.infeasible |-> out_data.last_result)
    else $error("infeasible result not marked last");
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while a result waits");
  a_flag_lo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.infeasible |-> out_data.new_lower > out_data.new_upper)
    else $error("infeasible flag without crossed bounds");
  // every accepted word leaves the input not ready in the cycle after it is taken
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready right after a word was taken");
endmodule

bind row_activity_bound_tightener rabt_checker u_rabt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
